FILE: rtl/pmfct_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store for the pulse meter totalizer.
// Used by every module of the block; depends on nothing.
package pmfct_pkg;

  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;
  localparam int TABLE_LO_W  = 64;
  localparam int TABLE_HI_W  = 40;
  localparam int OP_W        = 2;
  localparam int TIME_W      = 16;
  localparam int AMT_W       = 16;
  localparam int CORR_W      = 8;
  localparam int IDX_W       = 4;
  localparam int OUT_TOTAL_W = 24;
  localparam int ROUND_W     = 18;
  localparam int TABLE_LAST  = 12;

  // flow test diff*120/(dt*1000) >= k reduced to diff*3 >= k*25*dt
  localparam int FLOW_NUM    = 3;
  localparam int FLOW_DEN    = 25;

  // divide by 100 as a shift by two, then multiply by ceil(2^28 / 25)
  localparam int ROUND_BIAS  = 50;
  localparam int DIV_IN_W    = OUT_TOTAL_W - 1;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_25 = 24'd10737419;
  localparam int RECIP_SHIFT = 28;
  localparam int DIV_PROD_W  = DIV_IN_W + RECIP_W;

  localparam int PC_W        = 4;
  localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
  localparam logic [PC_W-1:0] PC_FLOW_STEP = 4'd3;
  localparam logic [PC_W-1:0] PC_APPLY     = 4'd5;
  localparam logic [PC_W-1:0] PC_EMIT      = 4'd8;
  localparam logic [PC_W-1:0] PC_LAST      = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_POLL     = 2'd0,
    OP_RESTART  = 2'd1,
    OP_FINISH   = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_TABLE_LO   = 3'd0,
    REG_TABLE_HI   = 3'd1,
    REG_OFFSET     = 3'd2,
    REG_WT_AMOUNT  = 3'd3,
    REG_WT_MODE    = 3'd4,
    REG_START_CORR = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    UOP_LATCH,
    UOP_AMOUNT,
    UOP_FLOW_INIT,
    UOP_FLOW_STEP,
    UOP_FLOW_DONE,
    UOP_APPLY,
    UOP_DIV_PREP,
    UOP_DIV_MUL,
    UOP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_REQ,
    COND_NO_FLOW,
    COND_FLOW_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic no_req;
    logic no_flow;
    logic flow_more;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [TABLE_LO_W-1:0] table_lo;
    logic [TABLE_HI_W-1:0] table_hi;
    logic [AMT_W-1:0]      offset;
    logic [AMT_W-1:0]      wt_amount;
    logic                  wt_mode;
    logic [CORR_W-1:0]     start_corr;
  } cfg_t;

  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = '{uop: UOP_LATCH, cond: COND_NO_REQ, target: PC_WAIT};
    unique case (pc)
      4'd0:    w = '{uop: UOP_LATCH,     cond: COND_NO_REQ,    target: PC_WAIT};
      4'd1:    w = '{uop: UOP_AMOUNT,    cond: COND_NO_FLOW,   target: PC_APPLY};
      4'd2:    w = '{uop: UOP_FLOW_INIT, cond: COND_NEVER,     target: PC_WAIT};
      4'd3:    w = '{uop: UOP_FLOW_STEP, cond: COND_FLOW_MORE, target: PC_FLOW_STEP};
      4'd4:    w = '{uop: UOP_FLOW_DONE, cond: COND_NEVER,     target: PC_WAIT};
      4'd5:    w = '{uop: UOP_APPLY,     cond: COND_NEVER,     target: PC_WAIT};
      4'd6:    w = '{uop: UOP_DIV_PREP,  cond: COND_NEVER,     target: PC_WAIT};
      4'd7:    w = '{uop: UOP_DIV_MUL,   cond: COND_NEVER,     target: PC_WAIT};
      4'd8:    w = '{uop: UOP_EMIT,      cond: COND_OUT_BUSY,  target: PC_EMIT};
      default: w = '{uop: UOP_LATCH,     cond: COND_NO_REQ,    target: PC_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [CORR_W-1:0] table_entry(input cfg_t cfg,
                                                    input logic [IDX_W-1:0] idx);
    logic [CORR_W-1:0] e;
    e = '0;
    if (idx < IDX_W'(8)) begin
      e = cfg.table_lo[{idx[2:0], 3'b000} +: CORR_W];
    end else if (idx <= IDX_W'(TABLE_LAST)) begin
      e = cfg.table_hi[{idx[2:0], 3'b000} +: CORR_W];
    end
    return e;
  endfunction

endpackage

FILE: rtl/pmfct_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank behind the APB-style port.
// Depends on pmfct_pkg for the register map and the cfg_t bundle.
module pmfct_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pmfct_pkg::ADDR_W-1:0] paddr,
  input  logic [pmfct_pkg::DATA_W-1:0] pwdata,
  output logic [pmfct_pkg::DATA_W-1:0] prdata,
  output pmfct_pkg::cfg_t              cfg
);
  import pmfct_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t sel;
  logic     wr_en;

  assign sel   = reg_idx_t'(paddr[5:3]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_TABLE_LO:   cfg_r.table_lo   <= pwdata[TABLE_LO_W-1:0];
        REG_TABLE_HI:   cfg_r.table_hi   <= pwdata[TABLE_HI_W-1:0];
        REG_OFFSET:     cfg_r.offset     <= pwdata[AMT_W-1:0];
        REG_WT_AMOUNT:  cfg_r.wt_amount  <= pwdata[AMT_W-1:0];
        REG_WT_MODE:    cfg_r.wt_mode    <= pwdata[0];
        REG_START_CORR: cfg_r.start_corr <= pwdata[CORR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_TABLE_LO:   prdata = DATA_W'(cfg_r.table_lo);
      REG_TABLE_HI:   prdata = DATA_W'(cfg_r.table_hi);
      REG_OFFSET:     prdata = DATA_W'(cfg_r.offset);
      REG_WT_AMOUNT:  prdata = DATA_W'(cfg_r.wt_amount);
      REG_WT_MODE:    prdata = DATA_W'(cfg_r.wt_mode);
      REG_START_CORR: prdata = DATA_W'(cfg_r.start_corr);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: rtl/pmfct_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on pmfct_pkg for the control word, status bundle and program.
module pmfct_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pmfct_pkg::dp_status_t status,
  output pmfct_pkg::ctl_word_t  ctl
);
  import pmfct_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            jump;

  assign ctl = ucode_rom(pc_r);

  always_comb begin
    case (ctl.cond)
      COND_NO_REQ:    jump = status.no_req;
      COND_NO_FLOW:   jump = status.no_flow;
      COND_FLOW_MORE: jump = status.flow_more;
      COND_OUT_BUSY:  jump = status.out_busy;
      default:        jump = 1'b0;
    endcase
    if (jump) begin
      pc_nxt = ctl.target;
    end else if (pc_r == PC_LAST) begin
      pc_nxt = PC_WAIT;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/pmfct_dp.sv
`timescale 1ns / 1ps
// Datapath: totals, flow index search, rounding divider and output register.
// Driven by the control word from pmfct_seq; depends on pmfct_pkg.
module pmfct_dp #(
  parameter int TOTAL_BITS     = 24,
  parameter int FLOW_INDEX_MAX = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pmfct_pkg::ctl_word_t           ctl,
  input  pmfct_pkg::cfg_t                cfg,
  output pmfct_pkg::dp_status_t          status,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pmfct_pkg::OP_W-1:0]     in_opcode,
  input  logic                           in_pulse_seen,
  input  logic [pmfct_pkg::TIME_W-1:0]   in_time_half_sec,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pmfct_pkg::OUT_TOTAL_W-1:0] out_total_amount,
  output logic [pmfct_pkg::ROUND_W-1:0]  out_total_rounded_hundreds,
  output logic [pmfct_pkg::AMT_W-1:0]    out_amount_added,
  output logic [pmfct_pkg::IDX_W-1:0]    out_flow_index,
  output logic [pmfct_pkg::CORR_W-1:0]   out_correction_now
);
  import pmfct_pkg::*;

  localparam int CMP_W = (TOTAL_BITS + 2 > 26) ? TOTAL_BITS + 2 : 26;

  opcode_t               op_r;
  logic                  pulse_r;
  logic [TIME_W-1:0]     now_r;
  logic [AMT_W-1:0]      add_amt_r;
  logic [CMP_W-1:0]      lhs_r;
  logic [CMP_W-1:0]      thr_r;
  logic [CMP_W-1:0]      step_r;
  logic [IDX_W-1:0]      idx_r;
  logic [TOTAL_BITS-1:0] running_total_r;
  logic [TOTAL_BITS-1:0] tlc_r;
  logic [TIME_W-1:0]     tlt_r;
  logic [CORR_W-1:0]     corr_r;
  logic [IDX_W-1:0]      last_idx_r;
  logic                  final_added_r;
  logic [DIV_IN_W-1:0]   div_in_r;
  logic [ROUND_W-1:0]    quo_r;
  logic                  out_valid_r;
  logic [OUT_TOTAL_W-1:0] out_total_r;
  logic [ROUND_W-1:0]    out_round_r;
  logic [AMT_W-1:0]      out_added_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [CORR_W-1:0]     out_corr_r;

  logic [AMT_W:0]        pulse_sum;
  logic [AMT_W-1:0]      pulse_amt;
  logic [AMT_W-1:0]      finish_amt;
  logic [TOTAL_BITS-1:0] diff;
  logic [TIME_W-1:0]     dt;
  logic [CMP_W-1:0]      step_val;
  logic [TOTAL_BITS:0]   total_sum;
  logic [TOTAL_BITS-1:0] total_sat;
  logic [OUT_TOTAL_W-1:0] shown;
  logic [OUT_TOTAL_W:0]  biased;
  logic [DIV_PROD_W-1:0] div_prod;
  logic                  flow_more;

  assign pulse_sum  = {1'b0, cfg.offset} + (AMT_W+1)'(corr_r);
  assign pulse_amt  = pulse_sum[AMT_W] ? '1 : pulse_sum[AMT_W-1:0];
  assign finish_amt = (cfg.offset >> 1) + AMT_W'(corr_r >> 1);
  assign diff       = (running_total_r > tlc_r) ? running_total_r - tlc_r : '0;
  assign dt         = now_r - tlt_r;
  assign step_val   = CMP_W'(dt) * CMP_W'(FLOW_DEN);
  assign total_sum  = {1'b0, running_total_r} + (TOTAL_BITS+1)'(add_amt_r);
  assign total_sat  = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
  assign shown      = OUT_TOTAL_W'(running_total_r);
  assign biased     = {1'b0, shown} + (OUT_TOTAL_W+1)'(ROUND_BIAS);
  assign div_prod   = DIV_PROD_W'(div_in_r) * DIV_PROD_W'(RECIP_25);
  assign flow_more  = (lhs_r >= thr_r) && (idx_r < IDX_W'(FLOW_INDEX_MAX));

  assign in_ready         = rst_n && (ctl.uop == UOP_LATCH);
  assign status.no_req    = !in_valid;
  assign status.no_flow   = !(op_r == OP_POLL && pulse_r && !cfg.wt_mode);
  assign status.flow_more = flow_more;
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid                  = out_valid_r;
  assign out_total_amount           = out_total_r;
  assign out_total_rounded_hundreds = out_round_r;
  assign out_amount_added           = out_added_r;
  assign out_flow_index             = out_idx_r;
  assign out_correction_now         = out_corr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_total_r <= '0;
      tlc_r           <= '0;
      tlt_r           <= '0;
      corr_r          <= '0;
      last_idx_r      <= '0;
      final_added_r   <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && ctl.uop != UOP_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.uop)
        UOP_LATCH: begin
          if (in_valid) begin
            op_r    <= opcode_t'(in_opcode);
            pulse_r <= in_pulse_seen;
            now_r   <= in_time_half_sec;
          end
        end
        UOP_AMOUNT: begin
          if (op_r == OP_POLL && pulse_r) begin
            add_amt_r <= cfg.wt_mode ? cfg.wt_amount : pulse_amt;
          end else if (op_r == OP_FINISH && !final_added_r) begin
            add_amt_r <= finish_amt;
          end else begin
            add_amt_r <= '0;
          end
        end
        UOP_FLOW_INIT: begin
          lhs_r  <= CMP_W'(diff) * CMP_W'(FLOW_NUM);
          step_r <= step_val;
          thr_r  <= step_val;
          idx_r  <= '0;
        end
        UOP_FLOW_STEP: begin
          if (flow_more) begin
            idx_r <= idx_r + IDX_W'(1);
            thr_r <= thr_r + step_r;
          end
        end
        UOP_FLOW_DONE: begin
          corr_r     <= table_entry(cfg, idx_r);
          last_idx_r <= idx_r;
          tlc_r      <= running_total_r;
          tlt_r      <= now_r;
        end
        UOP_APPLY: begin
          case (op_r)
            OP_POLL: running_total_r <= total_sat;
            OP_RESTART: begin
              running_total_r <= '0;
              tlc_r           <= '0;
              tlt_r           <= now_r;
              corr_r          <= cfg.start_corr;
              last_idx_r      <= '0;
              final_added_r   <= 1'b0;
            end
            OP_FINISH: begin
              if (!final_added_r) begin
                final_added_r   <= 1'b1;
                running_total_r <= total_sat;
              end
            end
            default: ;
          endcase
        end
        UOP_DIV_PREP: begin
          div_in_r <= biased[OUT_TOTAL_W:2];
        end
        UOP_DIV_MUL: begin
          quo_r <= div_prod[RECIP_SHIFT +: ROUND_W];
        end
        UOP_EMIT: begin
          if (!status.out_busy) begin
            out_valid_r <= 1'b1;
            out_total_r <= shown;
            out_round_r <= quo_r;
            out_added_r <= add_amt_r;
            out_idx_r   <= last_idx_r;
            out_corr_r  <= corr_r;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    last_idx_r <= IDX_W'(FLOW_INDEX_MAX))
    else $error("flow index above its limit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready)
    |=> (out_valid_r && $stable(out_total_r) && $stable(out_round_r)))
    else $error("result changed while waiting");

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uop == UOP_APPLY && op_r != OP_RESTART)
    |=> running_total_r >= $past(running_total_r))
    else $error("total decreased without restart");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uop == UOP_EMIT && !status.out_busy) |=> out_valid_r)
    else $error("result not presented after emit");
`endif

endmodule

FILE: rtl/pulse_meter_flow_corrected_total.sv
`timescale 1ns / 1ps
// Pulse meter totalizer with flow-dependent correction, top level.
// Depends on pmfct_pkg, pmfct_cfg, pmfct_seq and pmfct_dp.
//
// One request at a time is run by a small microprogram. When no flow index is computed
// (restart, finish, reserved opcode, poll without pulse, water test mode) the program
// goes from its amount step straight to its apply step; for a measuring pulse it first
// runs the flow index search, which takes one compare-and-add per cycle plus a final
// compare that ends it; the index is at most FLOW_INDEX_MAX. The rounded-hundreds figure
// is made by a shift by two and then a multiply by the reciprocal of 25. The result sits
// in an output register; while an earlier result waits the program holds in its emit
// step, and the next request is taken the cycle after the result is loaded. Configuration
// is 64-bit at byte address 8 * register index; write only while no request is in flight.
module pulse_meter_flow_corrected_total #(
  parameter int TOTAL_BITS     = 24,
  parameter int FLOW_INDEX_MAX = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pmfct_pkg::ADDR_W-1:0]    paddr,
  input  logic [pmfct_pkg::DATA_W-1:0]    pwdata,
  output logic [pmfct_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pmfct_pkg::OP_W-1:0]      in_opcode,
  input  logic                            in_pulse_seen,
  input  logic [pmfct_pkg::TIME_W-1:0]    in_time_half_sec,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pmfct_pkg::OUT_TOTAL_W-1:0] out_total_amount,
  output logic [pmfct_pkg::ROUND_W-1:0]   out_total_rounded_hundreds,
  output logic [pmfct_pkg::AMT_W-1:0]     out_amount_added,
  output logic [pmfct_pkg::IDX_W-1:0]     out_flow_index,
  output logic [pmfct_pkg::CORR_W-1:0]    out_correction_now
);
  import pmfct_pkg::*;

  cfg_t       cfg;
  ctl_word_t  ctl;
  dp_status_t status;

  assign pready = 1'b1;

  pmfct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pmfct_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  pmfct_dp #(
    .TOTAL_BITS     (TOTAL_BITS),
    .FLOW_INDEX_MAX (FLOW_INDEX_MAX)
  ) u_dp (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .ctl                        (ctl),
    .cfg                        (cfg),
    .status                     (status),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_opcode                  (in_opcode),
    .in_pulse_seen              (in_pulse_seen),
    .in_time_half_sec           (in_time_half_sec),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_total_amount           (out_total_amount),
    .out_total_rounded_hundreds (out_total_rounded_hundreds),
    .out_amount_added           (out_amount_added),
    .out_flow_index             (out_flow_index),
    .out_correction_now         (out_correction_now)
  );

endmodule
